/* design/sha_pkg.sv */
// Package for the subregion heap allocator: beat types, status codes,
// state machine encoding and subregion layout helpers. No dependencies.
`default_nettype none
package sha_pkg;

  localparam int unsigned HandleSlotsDefault = 12;
  localparam int unsigned Subregions = 40;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [13:0] request_bytes;
    logic [14:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] granted_offset;
    logic [13:0] granted_bytes;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_COMMIT,
    S_FREE,
    S_RESP
  } state_t;

  // Command from controller to datapath
  typedef struct packed {
    logic load;     // capture request, begin
    logic scan;     // evaluate one candidate run
    logic slot;     // step slot search
    logic commit;   // write mask and slot
    logic fail;     // latch failure status
    logic show;     // result register valid
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad;
    logic scan_done;
    logic found;
    logic slot_done;
    logic slot_hit;
  } sts_t;

  // Offset of a subregion
  function automatic logic [14:0] sr_offset(input logic [5:0] idx);
    logic [14:0] r;
    if (idx < 6'd8)       r = {3'd0, idx[2:0], 9'd0};
    else if (idx < 6'd16) r = 15'h1000 + {2'd0, idx[2:0], 10'd0};
    else if (idx < 6'd32) r = 15'h3000 + {2'd0, idx[3:0], 9'd0};
    else                  r = 15'h5000 + {2'd0, idx[2:0], 10'd0};
    return r;
  endfunction

  // Subregion of an offset, 40 when beyond the heap
  function automatic logic [5:0] sr_index(input logic [14:0] off);
    logic [5:0] r;
    if (off < 15'h1000)      r = {3'd0, off[11:9]};
    else if (off < 15'h3000) r = 6'd8 + {3'd0, 3'(off[13:10] - 4'd4)};
    else if (off < 15'h5000) r = 6'd16 + {2'd0, 4'(off[13:9] - 5'd24)};
    else if (off < 15'h7000) r = 6'd32 + {3'd0, 3'(off[14:10] - 5'd20)};
    else                     r = 6'd40;
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/subregion_heap_allocator_unit.sv */
// Subregion heap allocator top level: controller plus datapath.
// Allocate checks up to 40 candidate runs, one per cycle, then the handle slots
// one per cycle; free searches the handle slots one per cycle. One request at a
// time; the result register holds until taken. Synchronous reset clears the
// busy mask and all handle slots.
`default_nettype none
module subregion_heap_allocator_unit #(
  parameter int unsigned HANDLE_SLOTS = sha_pkg::HandleSlotsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sha_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sha_pkg::rsp_t      out_data
);
  import sha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  sha_dp #(.HANDLE_SLOTS(HANDLE_SLOTS)) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .rsp(out_data)
  );
endmodule
`default_nettype wire

/* design/sha_ctrl.sv */
// Controller state machine of the subregion heap allocator.
// Depends on sha_pkg.
`default_nettype none
module sha_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire sha_pkg::sts_t  sts,
  output sha_pkg::cmd_t       cmd
);
  import sha_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: begin
        if (sts.is_free) state_next = S_FREE;
        else if (sts.bad) state_next = S_RESP;
        else if (sts.found) state_next = S_SLOT;
        else if (sts.scan_done) state_next = S_RESP;
      end
      S_SLOT: begin
        if (sts.slot_hit) state_next = S_COMMIT;
        else if (sts.slot_done) state_next = S_RESP;
      end
      S_FREE: begin
        if (sts.slot_hit) state_next = S_COMMIT;
        else if (sts.slot_done) state_next = S_RESP;
      end
      S_COMMIT: state_next = S_RESP;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan = !sts.is_free && !sts.bad && !sts.found;
        cmd.fail = !sts.is_free && (sts.bad || (!sts.found && sts.scan_done));
      end
      S_SLOT, S_FREE: begin
        cmd.slot = !sts.slot_hit;
        cmd.fail = !sts.slot_hit && sts.slot_done;
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_RESP: begin
        out_valid = 1'b1;
        cmd.show = 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/sha_dp.sv */
// Datapath of the subregion heap allocator: busy mask, handle table,
// candidate scan sequencer and result register. Depends on sha_pkg.
`default_nettype none
module sha_dp #(
  parameter int unsigned HANDLE_SLOTS = sha_pkg::HandleSlotsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sha_pkg::req_t req,
  input  wire sha_pkg::cmd_t cmd,
  output sha_pkg::sts_t      sts,
  output sha_pkg::rsp_t      rsp
);
  import sha_pkg::*;

  localparam int unsigned SW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(HANDLE_SLOTS + 1);

  // Scan phases: each is a group with a run length
  typedef enum logic [2:0] {
    P_PAIR, P_G0, P_G1, P_G2, P_G3, P_END
  } phase_t;

  logic [Subregions-1:0] mask;
  logic [HANDLE_SLOTS-1:0] hvalid;
  logic [14:0] hoff [HANDLE_SLOTS];
  logic [13:0] hbytes [HANDLE_SLOTS];

  req_t        r;
  logic [2:0]  cls;      // 0:<=512 1:<=1024 2:<=1536 3:<=4096 4:big
  logic [1:0]  pass;     // 0 first size tier, 1 second tier
  phase_t      phase;
  logic [5:0]  pos;      // candidate start
  logic [5:0]  first;
  logic [3:0]  n;
  logic [13:0] bytes;
  logic        found;
  logic [CW-1:0] sidx;
  logic [SW-1:0] hit_slot;
  logic [2:0]  status;
  logic [14:0] roff;
  logic [13:0] rbytes;

  // Request class and run lengths
  logic        bad;
  logic [3:0]  n1k;
  assign bad  = (r.request_bytes == 14'd0) || (r.request_bytes > 14'h2000);
  assign n1k  = 4'((r.request_bytes + 14'd1023) >> 10);

  // First tier scans 512 groups except for the 1024-only classes
  logic g_first;
  assign g_first = (pass == 2'd0) && !(cls == 3'd1 || cls == 3'd4);

  // Upper group bound of the current phase
  logic [5:0] hi;
  always_comb begin
    hi = 6'd7;
    case (phase)
      P_G0: hi = (g_first ? 6'd7 : 6'd15);
      P_G1: hi = (g_first ? 6'd31 : 6'd39);
      default: ;
    endcase
  end

  // Run-free test of the candidate
  logic [5:0] pair_start;
  logic       run_ok;
  logic [5:0] endp;
  logic [Subregions-1:0] runm;
  always_comb begin
    case (pos[1:0])
      2'd0: pair_start = 6'd7;
      2'd1: pair_start = 6'd15;
      default: pair_start = 6'd31;
    endcase
  end
  logic [5:0] cand;
  assign cand = (phase == P_PAIR) ? pair_start : pos;
  assign endp = cand + 6'(n) - 6'd1;
  always_comb begin
    for (int k = 0; k < Subregions; k++)
      runm[k] = (6'(k) >= cand) && (6'(k) <= endp);
  end
  assign run_ok = ((runm & mask) == '0) && (endp < 6'd40) &&
                  ((phase == P_PAIR) || (endp <= hi));

  // Release mask for free
  logic [5:0] fstart;
  logic [3:0] fused;
  logic [13:0] fsz;
  logic [Subregions-1:0] fm;
  assign fstart = sr_index(r.block_offset);
  assign fsz = hbytes[hit_slot];
  always_comb begin
    if ((fstart == 6'd7 || fstart == 6'd15 || fstart == 6'd31) && fsz == 14'h600)
      fused = 4'd2;
    else if ((fstart >= 6'd8 && fstart <= 6'd15) || (fstart >= 6'd32 && fstart <= 6'd39))
      fused = 4'((fsz + 14'd1023) >> 10);
    else
      fused = 4'((fsz + 14'd511) >> 9);
    for (int k = 0; k < Subregions; k++)
      fm[k] = (6'(k) >= fstart) && (7'(k) < 7'(fstart) + 7'(fused));
  end

  logic [Subregions-1:0] am;
  always_comb begin
    for (int k = 0; k < Subregions; k++)
      am[k] = (6'(k) >= first) && (7'(k) < 7'(first) + 7'(n));
  end

  // Slot test at the current index
  logic [SW-1:0] si;
  logic          slot_hit;
  assign si = SW'(sidx);
  assign slot_hit = (sidx < CW'(HANDLE_SLOTS)) &&
                    (r.action ? (hvalid[si] && hoff[si] == r.block_offset)
                              : !hvalid[si]);

  assign sts.is_free   = r.action;
  assign sts.bad       = bad;
  assign sts.found     = found;
  assign sts.scan_done = (phase == P_END);
  assign sts.slot_hit  = slot_hit;
  assign sts.slot_done = (sidx >= CW'(HANDLE_SLOTS - 1));

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
      found <= 1'b0;
      pass <= 2'd0;
      sidx <= '0;
      pos <= 6'd0;
      if (req.request_bytes <= 14'h200) begin
        cls <= 3'd0; n <= 4'd1; bytes <= 14'd512; phase <= P_G0;
      end else if (req.request_bytes <= 14'h400) begin
        cls <= 3'd1; n <= 4'd1; bytes <= 14'd1024; phase <= P_G0; pos <= 6'd8;
      end else if (req.request_bytes <= 14'h600) begin
        cls <= 3'd2; n <= 4'd2; bytes <= 14'h600; phase <= P_PAIR;
      end else if (req.request_bytes <= 14'h1000) begin
        cls <= 3'd3; n <= 4'((req.request_bytes + 14'd511) >> 9);
        bytes <= 14'(((req.request_bytes + 14'd511) >> 9) << 9); phase <= P_G0;
      end else begin
        cls <= 3'd4; n <= 4'((req.request_bytes + 14'd1023) >> 10);
        bytes <= 14'(((req.request_bytes + 14'd1023) >> 10) << 10);
        phase <= P_G0; pos <= 6'd8;
      end
    end else if (cmd.scan) begin
      if (run_ok) begin
        found <= 1'b1;
        first <= cand;
      end else if (phase == P_PAIR) begin
        if (pos[1:0] == 2'd2) begin
          phase <= P_G0; pos <= 6'd0; n <= 4'd3;
        end else pos <= pos + 6'd1;
      end else if (pos + 6'(n) - 6'd1 < hi) begin
        pos <= pos + 6'd1;
      end else if (phase == P_G0) begin
        phase <= P_G1; pos <= g_first ? 6'd16 : 6'd32;
      end else if (g_first && (cls == 3'd0 || cls == 3'd3)) begin
        // fall back to the 1024 groups
        pass <= 2'd1; phase <= P_G0; pos <= 6'd8;
        n <= (cls == 3'd0) ? 4'd1 : n1k;
        bytes <= (cls == 3'd0) ? 14'd1024 : 14'({n1k, 10'd0});
      end else begin
        phase <= P_END;
      end
    end else if (cmd.slot) begin
      sidx <= sidx + CW'(1);
    end
    if (slot_hit) hit_slot <= si;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      roff <= '0; rbytes <= '0;
      if (r.action)          status <= ST_NOT_FOUND;
      else if (bad)          status <= ST_BAD_SIZE;
      else if (!found)       status <= ST_NO_SPACE;
      else                   status <= ST_NO_SLOT;
    end else if (cmd.commit) begin
      status <= ST_OK;
      if (r.action) begin
        roff <= r.block_offset; rbytes <= fsz;
      end else begin
        roff <= sr_offset(first); rbytes <= bytes;
      end
    end
  end
  assign rsp = '{status: status, granted_offset: roff, granted_bytes: rbytes};

  // Mask and handle table
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      hvalid <= '0;
    end else if (cmd.commit) begin
      if (r.action) begin
        mask <= mask & ~fm;
        hvalid[hit_slot] <= 1'b0;
      end else begin
        mask <= mask | am;
        hvalid[hit_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !r.action) begin
      hoff[hit_slot] <= sr_offset(first);
      hbytes[hit_slot] <= bytes;
    end
  end

  logic unused;
  assign unused = cmd.show;
endmodule
`default_nettype wire
